@@ rtl/spmv_pkg.sv @@
// ----------------------------------------------------------------------------
// spmv_pkg
// Shared types, opcodes and saturation helpers for the CSR sparse
// matrix-vector product block.
// ----------------------------------------------------------------------------
package spmv_pkg;

  localparam int unsigned IdxW     = 10;
  localparam int unsigned ValW     = 32;
  localparam int unsigned AccW     = 48;
  localparam int unsigned FracW    = 16;
  localparam int unsigned OutDepth = 8;
  localparam int unsigned OutPtrW  = $clog2(OutDepth);
  localparam int unsigned OutCntW  = OutPtrW + 1;

  typedef enum logic [1:0] {
    OpLoadX    = 2'd0,
    OpRowEntry = 2'd1,
    OpColEntry = 2'd2,
    OpColRead  = 2'd3
  } op_e;

  typedef logic [IdxW-1:0]        idx_t;
  typedef logic signed [ValW-1:0] val_t;
  typedef logic signed [AccW-1:0] acc_t;

  typedef struct packed {
    val_t value;
    logic sat;
  } sat_val_t;

  typedef struct packed {
    idx_t index;
    val_t value;
    logic sat;
  } result_t;

  // clamp a one-bit-grown accumulator sum back to the accumulator range
  function automatic acc_t sat_acc(input logic signed [AccW:0] sum);
    acc_t r;
    if (sum[AccW] != sum[AccW-1]) begin
      r = sum[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      r = sum[AccW-1:0];
    end
    return r;
  endfunction

  // clamp to the 32-bit result range and flag clipping
  function automatic sat_val_t sat_res(input logic signed [AccW:0] v);
    sat_val_t r;
    logic     all_one;
    logic     all_zero;
    all_one  = &v[AccW:ValW-1];
    all_zero = ~|v[AccW:ValW-1];
    if (all_one || all_zero) begin
      r.value = v[ValW-1:0];
      r.sat   = 1'b0;
    end else begin
      r.value = v[AccW] ? {1'b1, {(ValW-1){1'b0}}} : {1'b0, {(ValW-1){1'b1}}};
      r.sat   = 1'b1;
    end
    return r;
  endfunction

endpackage

@@ rtl/sparse_matvec_csr.sv @@
// ----------------------------------------------------------------------------
// sparse_matvec_csr
// Streaming CSR matrix-vector product, y = A x (+ y) and transposed sums,
// with Q16.16 values, 48-bit saturating accumulators and 32-bit results.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------
//  in      | sink      | in_valid_i / in_stall_o | operation, entry_index,
//          |           |                         | entry_row, entry_value,
//          |           |                         | addend, last_in_row
//  out     | source    | out_valid_o/out_stall_i | result_index, result_value,
//          |           |                         | saturated
//
//  One item per cycle unless the input is stalled. An accepted item passes the
//  stage registers (x read at accept, then multiply, accumulate with column
//  sum read-modify-write and bypass, addend and clamp) before its result is
//  written to the output queue, and can leave on the next edge. An eight-entry
//  result queue decouples output stalls; input stalls only when queued plus
//  in-flight results would fill it, or while the column sum memory is cleared
//  after reset, one entry a cycle over all min(MAX_DIM, 1024) entries.
// ----------------------------------------------------------------------------
module sparse_matvec_csr #(
  parameter int unsigned MAX_DIM = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [9:0]  entry_index_i,
  input  logic [9:0]  entry_row_i,
  input  logic signed [31:0] entry_value_i,
  input  logic signed [31:0] addend_i,
  input  logic        last_in_row_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [9:0]  result_index_o,
  output logic signed [31:0] result_value_o,
  output logic        saturated_o
);

  localparam int unsigned MemDepth =
    (MAX_DIM < 2**spmv_pkg::IdxW) ? MAX_DIM : 2**spmv_pkg::IdxW;
  localparam int unsigned AddrW = $clog2(MemDepth);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(MemDepth - 1);
  localparam spmv_pkg::idx_t LastRow = spmv_pkg::idx_t'(MemDepth - 1);
  localparam logic [spmv_pkg::OutCntW-1:0] QueueFull =
    spmv_pkg::OutCntW'(spmv_pkg::OutDepth);

  // ---------------------------------------------------------------- input
  spmv_pkg::op_e  in_op;
  logic           in_acc;
  logic           idx_ok;
  logic           row_ok;
  logic [AddrW-1:0] x_addr;
  logic           x_ok_d;

  // clear pass
  logic             clr_active_q;
  logic [AddrW-1:0] clr_addr_q;

  // stage 1: x read data
  logic             s1_valid_q;
  logic             s1_res_q;
  spmv_pkg::op_e    s1_op_q;
  spmv_pkg::idx_t   s1_idx_q;
  logic             s1_idx_ok_q;
  logic             s1_x_ok_q;
  spmv_pkg::val_t   s1_val_q;
  spmv_pkg::val_t   s1_add_q;
  logic             s1_last_q;
  spmv_pkg::val_t   x_rdata_q;
  spmv_pkg::val_t   x_eff;
  logic signed [2*spmv_pkg::ValW-1:0] prod_full;

  // stage 2: product and column sum read data
  logic             s2_valid_q;
  logic             s2_res_q;
  spmv_pkg::op_e    s2_op_q;
  spmv_pkg::idx_t   s2_idx_q;
  logic             s2_idx_ok_q;
  spmv_pkg::acc_t   s2_prod_q;
  spmv_pkg::val_t   s2_add_q;
  logic             s2_last_q;
  spmv_pkg::acc_t   col_rdata_q;
  spmv_pkg::acc_t   col_cur;
  spmv_pkg::acc_t   acc_base;
  spmv_pkg::acc_t   acc_new;
  logic             s2_is_row;
  logic             s2_row_end;

  // column memory write port and bypass
  logic             col_we;
  logic [AddrW-1:0] col_waddr;
  spmv_pkg::acc_t   col_wdata;
  logic             byp_valid_q;
  logic [AddrW-1:0] byp_addr_q;
  spmv_pkg::acc_t   byp_data_q;

  // row state
  spmv_pkg::acc_t   row_sum_q;
  spmv_pkg::idx_t   row_cnt_q;

  // stage 3: value before addend
  logic             s3_valid_q;
  spmv_pkg::idx_t   s3_idx_q;
  spmv_pkg::acc_t   s3_acc_q;
  spmv_pkg::val_t   s3_add_q;
  spmv_pkg::sat_val_t s3_res;

  // result queue
  spmv_pkg::result_t             queue_q [spmv_pkg::OutDepth];
  logic [spmv_pkg::OutPtrW-1:0]  wr_ptr_q;
  logic [spmv_pkg::OutPtrW-1:0]  rd_ptr_q;
  logic [spmv_pkg::OutCntW-1:0]  cnt_q;
  logic [spmv_pkg::OutCntW-1:0]  pending;
  logic [spmv_pkg::OutCntW-1:0]  occupancy;
  logic                          push;
  logic                          pop;

  // memories
  spmv_pkg::val_t x_mem   [MemDepth];
  spmv_pkg::acc_t col_mem [MemDepth];

  assign in_op     = spmv_pkg::op_e'(operation_i);
  assign in_acc    = in_valid_i && !in_stall_o;
  assign idx_ok    = 32'(entry_index_i) < MAX_DIM;
  assign row_ok    = 32'(entry_row_i) < MAX_DIM;
  assign x_addr    = (in_op == spmv_pkg::OpColEntry) ? entry_row_i[AddrW-1:0]
                                                     : entry_index_i[AddrW-1:0];
  assign x_ok_d    = (in_op == spmv_pkg::OpColEntry) ? row_ok : idx_ok;

  assign pending   = spmv_pkg::OutCntW'(s1_res_q) + spmv_pkg::OutCntW'(s2_res_q)
                   + spmv_pkg::OutCntW'(s3_valid_q);
  assign occupancy = cnt_q + pending;
  assign in_stall_o = clr_active_q || (occupancy >= QueueFull);

  // x vector memory
  always_ff @(posedge clk_i) begin
    if (in_acc && in_op == spmv_pkg::OpLoadX && idx_ok) begin
      x_mem[entry_index_i[AddrW-1:0]] <= entry_value_i;
    end
    x_rdata_q <= x_mem[x_addr];
  end

  // ------------------------------------------------------------- stage 1
  assign x_eff     = s1_x_ok_q ? x_rdata_q : '0;
  assign prod_full = s1_val_q * x_eff;

  // ------------------------------------------------------------- stage 2
  assign col_cur   = (byp_valid_q && byp_addr_q == s2_idx_q[AddrW-1:0]) ? byp_data_q
                                                                         : col_rdata_q;
  assign s2_is_row = s2_op_q == spmv_pkg::OpRowEntry;
  assign s2_row_end = s2_valid_q && s2_is_row && s2_last_q;
  assign acc_base  = s2_is_row ? row_sum_q : col_cur;
  assign acc_new   = spmv_pkg::sat_acc({acc_base[spmv_pkg::AccW-1], acc_base}
                                     + {s2_prod_q[spmv_pkg::AccW-1], s2_prod_q});

  always_comb begin
    col_we    = 1'b0;
    col_waddr = s2_idx_q[AddrW-1:0];
    col_wdata = acc_new;
    if (clr_active_q) begin
      col_we    = 1'b1;
      col_waddr = clr_addr_q;
      col_wdata = '0;
    end else if (s2_valid_q && s2_idx_ok_q) begin
      case (s2_op_q)
        spmv_pkg::OpColEntry: begin
          col_we = 1'b1;
        end
        spmv_pkg::OpColRead: begin
          col_we    = 1'b1;
          col_wdata = '0;
        end
        default: begin
          col_we = 1'b0;
        end
      endcase
    end
  end

  // column sum memory; the bypass covers the write made on the read's edge
  always_ff @(posedge clk_i) begin
    if (col_we) begin
      col_mem[col_waddr] <= col_wdata;
    end
    col_rdata_q <= col_mem[s1_idx_q[AddrW-1:0]];
  end

  // ------------------------------------------------------------- stage 3
  assign s3_res = spmv_pkg::sat_res({s3_acc_q[spmv_pkg::AccW-1], s3_acc_q}
                + (spmv_pkg::AccW+1)'(s3_add_q));

  // ------------------------------------------------------------- queue
  assign push        = s3_valid_q;
  assign out_valid_o = cnt_q != '0;
  assign pop         = out_valid_o && !out_stall_i;

  assign result_index_o = queue_q[rd_ptr_q].index;
  assign result_value_o = queue_q[rd_ptr_q].value;
  assign saturated_o    = queue_q[rd_ptr_q].sat;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
      s1_valid_q   <= 1'b0;
      s1_res_q     <= 1'b0;
      s2_valid_q   <= 1'b0;
      s2_res_q     <= 1'b0;
      s3_valid_q   <= 1'b0;
      byp_valid_q  <= 1'b0;
      row_sum_q    <= '0;
      row_cnt_q    <= '0;
      wr_ptr_q     <= '0;
      rd_ptr_q     <= '0;
      cnt_q        <= '0;
    end else begin
      if (clr_active_q) begin
        if (clr_addr_q == LastAddr) begin
          clr_active_q <= 1'b0;
        end else begin
          clr_addr_q <= clr_addr_q + 1'b1;
        end
      end

      // loads finish at the memory write
      s1_valid_q  <= in_acc && in_op != spmv_pkg::OpLoadX;
      s1_res_q    <= in_acc && ((in_op == spmv_pkg::OpRowEntry && last_in_row_i)
                                || in_op == spmv_pkg::OpColRead);
      s2_valid_q  <= s1_valid_q;
      s2_res_q    <= s1_res_q;
      s3_valid_q  <= s2_res_q;
      byp_valid_q <= col_we && !clr_active_q;

      if (s2_valid_q && s2_is_row) begin
        row_sum_q <= s2_last_q ? '0 : acc_new;
      end
      if (s2_row_end) begin
        row_cnt_q <= (row_cnt_q == LastRow) ? '0 : row_cnt_q + 1'b1;
      end

      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    s1_op_q     <= in_op;
    s1_idx_q    <= entry_index_i;
    s1_idx_ok_q <= idx_ok;
    s1_x_ok_q   <= x_ok_d;
    s1_val_q    <= entry_value_i;
    s1_add_q    <= addend_i;
    s1_last_q   <= last_in_row_i;

    // floor of the Q32.32 product to Q16.16; it always fits 48 bits
    s2_op_q     <= s1_op_q;
    s2_idx_q    <= s1_idx_q;
    s2_idx_ok_q <= s1_idx_ok_q;
    s2_prod_q   <= prod_full[spmv_pkg::AccW+spmv_pkg::FracW-1:spmv_pkg::FracW];
    s2_add_q    <= s1_add_q;
    s2_last_q   <= s1_last_q;

    byp_addr_q  <= col_waddr;
    byp_data_q  <= col_wdata;

    if (s2_is_row) begin
      s3_idx_q <= row_cnt_q;
      s3_acc_q <= acc_new;
      s3_add_q <= s2_add_q;
    end else begin
      s3_idx_q <= s2_idx_q;
      s3_acc_q <= s2_idx_ok_q ? col_cur : '0;
      s3_add_q <= '0;
    end

    if (push) begin
      queue_q[wr_ptr_q] <= '{index: s3_idx_q, value: s3_res.value, sat: s3_res.sat};
    end
  end

`ifndef SYNTH
  // queued plus in-flight results never exceed the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) occupancy <= QueueFull)
    else $error("result queue overcommitted");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |-> cnt_q < QueueFull)
    else $error("push into full result queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_active_q |-> !s1_valid_q && !s2_valid_q && !s3_valid_q)
    else $error("item in flight during column clear");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_row_end |=> row_sum_q == '0)
    else $error("row sum not cleared at row end");
`endif

endmodule

@@ sim/sparse_matvec_csr_tb.sv @@
// ----------------------------------------------------------------------------
// sparse_matvec_csr_tb
// Self-checking bench for the CSR matrix-vector block. A scoreboard predicts
// row results and column-sum reads from every accepted item and compares the
// results in order. Stimulus is a directed opening, then row-heavy random
// traffic with random idle bursts on both sides and long output back-pressure.
// ----------------------------------------------------------------------------
module sparse_matvec_csr_tb;

  localparam spmv_pkg::val_t ValMax = 32'h7FFF_FFFF;
  localparam spmv_pkg::val_t ValMin = 32'h8000_0000;
  localparam spmv_pkg::val_t ValOne = 32'h0001_0000;
  localparam int unsigned ItemTarget = 1750;
  localparam int unsigned TailItems  = 200;
  localparam int unsigned RowTarget  = 1030;
  localparam int unsigned SweepRows  = 680;
  localparam int unsigned LongHold   = 400;

  class matvec_scoreboard;
    localparam longint AccMax = 64'sh7FFF_FFFF_FFFF;
    localparam longint AccMin = -64'sh8000_0000_0000;
    localparam longint ResMax = 64'sh7FFF_FFFF;
    localparam longint ResMin = -64'sh8000_0000;

    spmv_pkg::val_t    x_vec [1024];
    longint            col_sum [1024];
    longint            row_sum;
    spmv_pkg::idx_t    row_num;
    spmv_pkg::result_t expected_q [$];
    int                fails;
    int                shown;

    function new();
      foreach (x_vec[i]) x_vec[i] = '0;
      foreach (col_sum[i]) col_sum[i] = 0;
      row_sum = 0;
      row_num = '0;
      fails   = 0;
      shown   = 0;
    endfunction

    // q16.16 product, floored
    function longint fx_mul(spmv_pkg::val_t a, spmv_pkg::val_t b);
      longint p;
      p = longint'(a) * longint'(b);
      return p >>> 16;
    endfunction

    function longint acc_clip(longint v);
      if (v > AccMax) return AccMax;
      if (v < AccMin) return AccMin;
      return v;
    endfunction

    function spmv_pkg::result_t make_result(spmv_pkg::idx_t i, longint v);
      spmv_pkg::result_t r;
      r.index = i;
      r.sat   = 1'b0;
      if (v > ResMax) begin
        v     = ResMax;
        r.sat = 1'b1;
      end else if (v < ResMin) begin
        v     = ResMin;
        r.sat = 1'b1;
      end
      r.value = v[31:0];
      return r;
    endfunction

    function void note_item(spmv_pkg::op_e op, spmv_pkg::idx_t idx, spmv_pkg::idx_t row,
                            spmv_pkg::val_t v, spmv_pkg::val_t add, logic last);
      case (op)
        spmv_pkg::OpLoadX: x_vec[idx] = v;
        spmv_pkg::OpRowEntry: begin
          row_sum = acc_clip(row_sum + fx_mul(v, x_vec[idx]));
          if (last) begin
            expected_q.push_back(make_result(row_num, row_sum + longint'(add)));
            row_sum = 0;
            row_num = row_num + 1'b1;
          end
        end
        spmv_pkg::OpColEntry: col_sum[idx] = acc_clip(col_sum[idx] + fx_mul(v, x_vec[row]));
        default: begin
          expected_q.push_back(make_result(idx, col_sum[idx]));
          col_sum[idx] = 0;
        end
      endcase
    endfunction

    function void check_result(spmv_pkg::idx_t idx, spmv_pkg::val_t v, logic sat);
      spmv_pkg::result_t want;
      if (expected_q.size() == 0) begin
        fails++;
        if (shown < 10) begin
          shown++;
          $display("unexpected result: index %0d value %0d sat %0b", idx, v, sat);
        end
        return;
      end
      want = expected_q.pop_front();
      if (want.index !== idx || want.value !== v || want.sat !== sat) begin
        fails++;
        if (shown < 10) begin
          shown++;
          $display("mismatch: expected index %0d value %0d sat %0b, %s %0d %s %0d %s %0b",
                   want.index, want.value, want.sat, "got index", idx, "value", v,
                   "sat", sat);
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic           clk        = 1'b0;
  logic           rst_n      = 1'b0;
  logic           in_valid   = 1'b0;
  logic           in_stall;
  logic [1:0]     operation  = '0;
  logic [9:0]     entry_index = '0;
  logic [9:0]     entry_row  = '0;
  spmv_pkg::val_t entry_value = '0;
  spmv_pkg::val_t addend     = '0;
  logic           last_in_row = 1'b0;
  logic           out_valid;
  logic           out_stall  = 1'b0;
  logic [9:0]     res_index;
  spmv_pkg::val_t res_value;
  logic           res_sat;

  matvec_scoreboard sb;
  spmv_pkg::idx_t x_known [$];
  bit          x_seen [1024];
  int unsigned items_sent = 0;
  int unsigned rows_sent  = 0;
  bit          calm       = 1'b0;
  bit          quiet      = 1'b0;
  bit          hold_req   = 1'b0;
  int          hold_left  = 0;

  always #5 clk = ~clk;

  sparse_matvec_csr i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .operation_i    (operation),
    .entry_index_i  (entry_index),
    .entry_row_i    (entry_row),
    .entry_value_i  (entry_value),
    .addend_i       (addend),
    .last_in_row_i  (last_in_row),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .result_index_o (res_index),
    .result_value_o (res_value),
    .saturated_o    (res_sat)
  );

  function automatic spmv_pkg::val_t rand_value();
    case ($urandom_range(0, 9))
      0, 1, 2: return spmv_pkg::val_t'(int'($urandom_range(0, 1048575)) - 524288);
      3, 4:    return spmv_pkg::val_t'($urandom);
      5:       return spmv_pkg::val_t'(int'($urandom_range(0, 33554431)) - 16777216);
      6:       return ValMax;
      7:       return ValMin;
      8:       return '0;
      default: return spmv_pkg::val_t'(int'($urandom_range(0, 131071)) - 65536);
    endcase
  endfunction

  // only x entries written since reset may be read
  function automatic spmv_pkg::idx_t pick_x();
    return x_known[$urandom_range(0, x_known.size() - 1)];
  endfunction

  function automatic spmv_pkg::idx_t pick_col();
    if ($urandom_range(0, 1) == 0) return spmv_pkg::idx_t'($urandom_range(0, 15));
    return spmv_pkg::idx_t'($urandom);
  endfunction

  task automatic send(spmv_pkg::op_e op, spmv_pkg::idx_t idx, spmv_pkg::idx_t row,
                      spmv_pkg::val_t v, spmv_pkg::val_t add, logic last);
    if (!calm && !quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    entry_index <= idx;
    entry_row   <= row;
    entry_value <= v;
    addend      <= add;
    last_in_row <= last;
    do @(posedge clk); while (in_stall);
    sb.note_item(op, idx, row, v, add, last);
    items_sent++;
    if (op == spmv_pkg::OpRowEntry && last) rows_sent++;
  endtask

  task automatic load_x(spmv_pkg::idx_t i, spmv_pkg::val_t v);
    if (!x_seen[i]) begin
      x_seen[i] = 1'b1;
      x_known.push_back(i);
    end
    send(spmv_pkg::OpLoadX, i, spmv_pkg::idx_t'($urandom), v, rand_value(), 1'($urandom));
  endtask

  task automatic row_item(spmv_pkg::idx_t i, spmv_pkg::val_t v, spmv_pkg::val_t add,
                          logic last);
    send(spmv_pkg::OpRowEntry, i, spmv_pkg::idx_t'($urandom), v, add, last);
  endtask

  task automatic col_item(spmv_pkg::idx_t col, spmv_pkg::idx_t xi, spmv_pkg::val_t v);
    send(spmv_pkg::OpColEntry, col, xi, v, rand_value(), 1'($urandom));
  endtask

  task automatic read_col(spmv_pkg::idx_t col);
    send(spmv_pkg::OpColRead, col, spmv_pkg::idx_t'($urandom), rand_value(), rand_value(),
         1'($urandom));
  endtask

  // sender stops until every queued result has come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic rand_sequence();
    int             kind;
    int             n;
    spmv_pkg::idx_t col;
    spmv_pkg::op_e  op;
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      n = $urandom_range(1, 3);
      for (int k = 0; k < n; k++) row_item(pick_x(), rand_value(), rand_value(), k == n - 1);
    end else if (kind < 60) begin
      row_item(pick_x(), '0, rand_value(), 1'b1);
    end else if (kind < 70) begin
      n = $urandom_range(1, 3);
      repeat (n) load_x(spmv_pkg::idx_t'($urandom), rand_value());
    end else if (kind < 82) begin
      col = pick_col();
      n = $urandom_range(1, 5);
      repeat (n) col_item(col, pick_x(), rand_value());
      if ($urandom_range(0, 1) == 0) read_col(col);
    end else if (kind < 92) begin
      read_col(pick_col());
    end else begin
      // out-of-order traffic, row entries may interleave with anything
      op = spmv_pkg::op_e'($urandom_range(0, 3));
      case (op)
        spmv_pkg::OpLoadX:    load_x(spmv_pkg::idx_t'($urandom), rand_value());
        spmv_pkg::OpRowEntry: row_item(pick_x(), rand_value(), rand_value(), 1'($urandom));
        spmv_pkg::OpColEntry: col_item(spmv_pkg::idx_t'($urandom), pick_x(), rand_value());
        default:              read_col(spmv_pkg::idx_t'($urandom));
      endcase
    end
  endtask

  initial begin
    int unsigned tail_end;
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    load_x(10'd0, ValMax);
    load_x(10'd1023, ValMin);
    load_x(10'd1, ValOne);
    load_x(10'd2, 32'hFFFF_FFFF);
    // largest products, row result clips
    row_item(10'd0, ValMax, '0, 1'b0);
    row_item(10'd1023, ValMin, '0, 1'b1);
    // accumulator clips high, then negative addend
    repeat (2) row_item(10'd0, ValMax, ValMin, 1'b0);
    row_item(10'd0, ValMax, ValMin, 1'b1);
    // smallest negative product rounds down to -1
    row_item(10'd2, 32'sd1, '0, 1'b1);
    row_item(10'd1, ValOne, ValMax, 1'b1);
    // empty row gives the addend alone
    row_item(10'd1, '0, ValMin, 1'b1);
    // accumulator clips low
    repeat (2) row_item(10'd0, ValMin, ValMax, 1'b0);
    row_item(10'd0, ValMin, ValMax, 1'b1);
    col_item(10'd1023, 10'd0, ValMax);
    col_item(10'd1023, 10'd1023, ValMax);
    col_item(10'd1023, 10'd2, ValMin);
    read_col(10'd1023);
    read_col(10'd1023);
    read_col(10'd5);
    repeat (3) col_item(10'd7, 10'd1023, ValMax);
    read_col(10'd7);
    drain();

    // output held off while single-entry rows keep coming
    hold_req = 1'b1;
    repeat (SweepRows) row_item(pick_x(), rand_value(), rand_value(), 1'b1);

    while (items_sent < ItemTarget || rows_sent < RowTarget) begin
      if ($urandom_range(0, 39) == 0) calm = !calm;
      rand_sequence();
      if ($urandom_range(0, 199) == 0) drain();
    end

    quiet = 1'b1;
    tail_end = items_sent + TailItems;
    while (items_sent < tail_end) rand_sequence();

    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (20) @(posedge clk);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) sb.check_result(res_index, res_value, res_sat);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!calm && !quiet && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(0, 9);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #4000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/spmv_pkg.sv
rtl/sparse_matvec_csr.sv
sim/sparse_matvec_csr_tb.sv
